@@ src/sbbf_pkg.sv @@
package sbbf_pkg;

    // Geometry of one filter block: eight 32-bit words.
    localparam int WORDS_PER_BLOCK = 8;
    localparam int WORD_W          = 32;
    localparam int BLOCK_W         = WORDS_PER_BLOCK * WORD_W;
    localparam int BIT_POS_W       = 5;

    // Store size and register defaults.
    localparam int         MAX_BLOCKS_LOG2_DEFAULT = 10;
    localparam int         CFG_W                   = 4;
    localparam logic [3:0] BLOCK_COUNT_LOG2_RESET  = 4'd10;

    // Mode codes carried on the input tuser bit.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    // Standard split-block salts, one per word of a block.
    localparam logic [WORD_W-1:0] SALT [WORDS_PER_BLOCK] = '{
        32'h47b6137b, 32'h44974d91, 32'h8824ad5b, 32'ha2b7289d,
        32'h705495c7, 32'h2df1424b, 32'h9efc4947, 32'h5c6bfb31
    };

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_CHECK
    } t_state;

endpackage

@@ src/split_block_bloom_filter_core.sv @@
// Split-block Bloom filter with a stream input and a stream output.
// Input beats carry a 64-bit key hash on s_axis_tdata and the mode on
// s_axis_tuser (0 inserts the hash, 1 queries it). Only queries produce an
// output beat; its tdata bit 0 is 1 when all eight bits of the key are set.
// The block count register (log2 of the blocks in use) is written through
// i_cfg_wr_en / i_cfg_wr_data; the user must write it only while the filter
// is idle, which the block does not enforce. Values above the store size
// saturate. Changing it does not clear the store. Each beat goes through
// accept and block index, eight salt products, then the read-modify-write
// or check on the registered block read from the single-port store. One
// beat is in flight at a time, so a new beat is accepted only after the
// last one finishes, and a query's result is registered at its check step.
// After reset the store is swept to zero, one block per cycle, over all
// 2^MAX_BLOCKS_LOG2 blocks (1024 by default); s_axis_tready stays low then.
// The result sits in an output register, so a new input beat is taken while
// a result waits. When the receiver stalls with a result pending, a further
// query holds in its final step until the output register frees up.
module split_block_bloom_filter_core #(
    parameter int MAX_BLOCKS_LOG2 = sbbf_pkg::MAX_BLOCKS_LOG2_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Configuration: block_count_log2.
    input  logic                     i_cfg_wr_en,
    input  logic [sbbf_pkg::CFG_W-1:0] i_cfg_wr_data,
    // Input stream.
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [63:0]              s_axis_tdata,   // [63:0] hash
    input  logic                     s_axis_tuser,   // [0] mode
    // Output stream.
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [7:0]               m_axis_tdata    // [0] found, [7:1] zero
);
    import sbbf_pkg::*;

    localparam int ADDR_W = (MAX_BLOCKS_LOG2 > 0) ? MAX_BLOCKS_LOG2 : 1;
    localparam int DEPTH  = 1 << ADDR_W;

    // Control state.
    t_state                     r_state;
    t_state                     n_state;
    logic [ADDR_W-1:0]          r_clr_cnt;
    logic [CFG_W-1:0]           r_block_count_log2;
    logic                       r_out_valid;

    // Item payload.
    logic                       r_mode;
    logic [ADDR_W-1:0]          r_blk;
    logic [WORD_W-1:0]          r_key;
    logic [BIT_POS_W-1:0]       r_pos [WORDS_PER_BLOCK];
    logic                       r_found;

    // Filter store and its registered read data.
    logic [BLOCK_W-1:0]         r_store [DEPTH];
    logic [BLOCK_W-1:0]         r_rd_data;

    // Decoded controls.
    logic                       w_out_free;
    logic                       w_rd_en;
    logic                       w_wr_en;
    logic [ADDR_W-1:0]          w_wr_addr;
    logic [BLOCK_W-1:0]         w_wr_data;
    logic                       w_out_load;
    logic [CFG_W-1:0]           w_lg_sat;
    logic [31:0]                w_blk_full;
    logic [BLOCK_W-1:0]         w_mask;
    logic [WORD_W-1:0]          w_prod [WORDS_PER_BLOCK];
    logic                       w_found;
    logic                       w_in_fire;

    // Block index: the top lg bits of the hash's high half.
    always_comb begin
        if ({1'b0, r_block_count_log2} > 5'(MAX_BLOCKS_LOG2)) begin
            w_lg_sat = CFG_W'(MAX_BLOCKS_LOG2);
        end else begin
            w_lg_sat = r_block_count_log2;
        end
        w_blk_full = s_axis_tdata[63:32] >> (6'd32 - {2'b00, w_lg_sat});
    end

    // Salt products, one multiplier per word lane.
    always_comb begin
        for (int i = 0; i < WORDS_PER_BLOCK; i++) begin
            w_prod[i] = r_key * SALT[i];
        end
    end

    // Bit masks of the key and the membership check.
    always_comb begin
        for (int i = 0; i < WORDS_PER_BLOCK; i++) begin
            w_mask[i*WORD_W +: WORD_W] = WORD_W'(1) << r_pos[i];
        end
        w_found = ((r_rd_data & w_mask) == w_mask);
    end

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_in_fire  = s_axis_tvalid && s_axis_tready;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (&r_clr_cnt) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_axis_tvalid) n_state = ST_HASH;
            end
            ST_HASH: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (r_mode == MODE_INSERT || w_out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        s_axis_tready = 1'b0;
        w_rd_en       = 1'b0;
        w_wr_en       = 1'b0;
        w_wr_addr     = r_blk;
        w_wr_data     = r_rd_data | w_mask;
        w_out_load    = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr_cnt;
                w_wr_data = '0;
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_HASH: begin
                w_rd_en = 1'b1;
            end
            ST_CHECK: begin
                w_wr_en    = (r_mode == MODE_INSERT);
                w_out_load = (r_mode == MODE_QUERY) && w_out_free;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= ST_CLEAR;
            r_clr_cnt          <= '0;
            r_block_count_log2 <= BLOCK_COUNT_LOG2_RESET;
            r_out_valid        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cfg_wr_en) begin
                r_block_count_log2 <= i_cfg_wr_data;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_mode <= s_axis_tuser;
            r_key  <= s_axis_tdata[31:0];
            r_blk  <= w_blk_full[ADDR_W-1:0];
        end
        if (r_state == ST_HASH) begin
            for (int i = 0; i < WORDS_PER_BLOCK; i++) begin
                r_pos[i] <= w_prod[i][WORD_W-1 -: BIT_POS_W];
            end
        end
        if (w_out_load) begin
            r_found <= w_found;
        end
    end

    // Filter store: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_store[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_store[r_blk];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_found};

endmodule
